FILE: design/trrb_pkg.sv
// Shared types and constants of the trace record ring buffer.
// No dependencies; every other design file imports this package.
package trrb_pkg;

  localparam int RING_DEPTH = 1024;                 // power of two, 2 .. 1048576
  localparam int RING_AW    = $clog2(RING_DEPTH);
  localparam int Q_DEPTH    = 2;                    // power of two
  localparam int Q_AW       = $clog2(Q_DEPTH);
  localparam int Q_CW       = $clog2(Q_DEPTH + 1);
  localparam int CFG_AW     = 5;
  localparam int CFG_DW     = 64;

  localparam logic [1:0] REG_FILTER_EN  = 2'd0;
  localparam logic [1:0] REG_WIN_BASE   = 2'd1;
  localparam logic [1:0] REG_WIN_END    = 2'd2;
  localparam logic [1:0] REG_STAMP_EN   = 2'd3;

  typedef logic [RING_AW-1:0] ring_ptr_t;

  typedef enum logic {
    OP_RECORD = 1'b0,
    OP_DRAIN  = 1'b1
  } op_t;

  typedef enum logic {
    BK_IDLE,
    BK_READ
  } back_state_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [31:0] thread;
    logic [63:0] location;
    logic [63:0] target;
    logic [63:0] stamp;
  } entry_t;

  typedef struct packed {
    op_t    op;
    logic   in_window;
    entry_t entry;
  } cmd_t;

  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } q_head_t;

  typedef struct packed {
    logic        filter_en;
    logic [63:0] win_base;
    logic [63:0] win_end;
    logic        stamp_en;
  } cfg_t;

  typedef struct packed {
    logic        stored;
    logic        dropped;
    logic        in_window;
    logic        hit;
    entry_t      entry;
    logic        now_empty;
    logic [63:0] total_seen;
    logic [63:0] total_lost;
  } result_t;

endpackage

FILE: design/trrb_front.sv
// Front end: takes input beats, tests the location against the filter
// window and masks the timestamp. Depends on trrb_pkg.
module trrb_front (
  input  logic           in_valid,
  output logic           in_ready,
  input  logic           in_op,
  input  logic [2:0]     in_kind,
  input  logic [31:0]    in_thread_tag,
  input  logic [63:0]    in_location,
  input  logic [63:0]    in_target,
  input  logic [63:0]    in_stamp,
  input  trrb_pkg::cfg_t cfg,
  input  logic           q_full,
  output logic           push,
  output trrb_pkg::cmd_t push_cmd
);
  import trrb_pkg::*;

  logic hit_window;

  assign hit_window = !cfg.filter_en ||
                      ((in_location >= cfg.win_base) && (in_location < cfg.win_end));

  assign in_ready = !q_full;
  assign push     = in_valid && !q_full;

  always_comb begin
    push_cmd                = '0;
    push_cmd.op             = op_t'(in_op);
    push_cmd.in_window      = hit_window;
    push_cmd.entry.kind     = in_kind;
    push_cmd.entry.thread   = in_thread_tag;
    push_cmd.entry.location = in_location;
    push_cmd.entry.target   = in_target;
    push_cmd.entry.stamp    = cfg.stamp_en ? in_stamp : 64'd0;
  end

endmodule

FILE: design/trrb_queue.sv
// Short command queue between front and back end.
// Depends on trrb_pkg.
module trrb_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  trrb_pkg::cmd_t    push_cmd,
  output logic              full,
  output trrb_pkg::q_head_t q_head,
  input  logic              pop
);
  import trrb_pkg::*;

  cmd_t              slot_r [Q_DEPTH];
  logic [Q_AW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [Q_AW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [Q_CW-1:0]   count_r, count_nxt;
  logic              do_pop;

  assign full   = (count_r == Q_CW'(Q_DEPTH));
  assign do_pop = pop && (count_r != '0);

  assign q_head.valid = (count_r != '0);
  assign q_head.cmd   = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push   ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

FILE: design/trrb_back.sv
// Back end: ring memory, head/tail pointers, counters and result register.
// Depends on trrb_pkg.
module trrb_back (
  input  logic              clk,
  input  logic              rst_n,
  input  trrb_pkg::q_head_t q_head,
  output logic              pop,
  output logic              out_valid,
  input  logic              out_ready,
  output trrb_pkg::result_t result
);
  import trrb_pkg::*;

  entry_t      mem [RING_DEPTH];
  entry_t      rd_data_r;
  logic        wr_en, rd_en;

  back_state_t state_r, state_nxt;
  ring_ptr_t   head_r, head_nxt;
  ring_ptr_t   tail_r, tail_nxt;
  logic [63:0] seen_r, seen_nxt;
  logic [63:0] lost_r, lost_nxt;
  logic        ovld_r, ovld_nxt;
  result_t     res_r, res_nxt;
  result_t     pend_r, pend_nxt;
  logic        out_free;

  assign out_free  = !ovld_r || out_ready;
  assign out_valid = ovld_r;
  assign result    = res_r;

  always_comb begin
    state_nxt = state_r;
    head_nxt  = head_r;
    tail_nxt  = tail_r;
    seen_nxt  = seen_r;
    lost_nxt  = lost_r;
    ovld_nxt  = ovld_r && !out_ready;
    res_nxt   = res_r;
    pend_nxt  = pend_r;
    pop       = 1'b0;
    wr_en     = 1'b0;
    rd_en     = 1'b0;
    case (state_r)
      BK_IDLE: begin
        if (q_head.valid && out_free) begin
          pop               = 1'b1;
          res_nxt           = '0;
          res_nxt.in_window = q_head.cmd.in_window;
          if (q_head.cmd.op == OP_RECORD) begin
            if (ring_ptr_t'(head_r + 1'b1) == tail_r) begin
              lost_nxt        = lost_r + 64'd1;
              res_nxt.dropped = 1'b1;
            end else begin
              wr_en          = 1'b1;
              head_nxt       = head_r + 1'b1;
              seen_nxt       = seen_r + 64'd1;
              res_nxt.stored = 1'b1;
            end
            ovld_nxt = 1'b1;
          end else if (head_r != tail_r) begin
            // fetch the oldest slot; the beat goes out once read data lands
            rd_en     = 1'b1;
            tail_nxt  = tail_r + 1'b1;
            state_nxt = BK_READ;
          end else begin
            ovld_nxt = 1'b1;
          end
          res_nxt.now_empty  = (head_nxt == tail_nxt);
          res_nxt.total_seen = seen_nxt;
          res_nxt.total_lost = lost_nxt;
          pend_nxt           = res_nxt;
        end
      end
      BK_READ: begin
        if (out_free) begin
          res_nxt       = pend_r;
          res_nxt.hit   = 1'b1;
          res_nxt.entry = rd_data_r;
          ovld_nxt      = 1'b1;
          state_nxt     = BK_IDLE;
        end
      end
      default: begin
        state_nxt = BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= BK_IDLE;
      head_r  <= '0;
      tail_r  <= '0;
      seen_r  <= '0;
      lost_r  <= '0;
      ovld_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      seen_r  <= seen_nxt;
      lost_r  <= lost_nxt;
      ovld_r  <= ovld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res_r  <= res_nxt;
    pend_r <= pend_nxt;
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[head_r] <= q_head.cmd.entry;
    end
    if (rd_en) begin
      rd_data_r <= mem[tail_r];
    end
  end

endmodule

FILE: design/trace_record_ring_buffer.sv
// Top level of the trace record ring buffer: register file, front end,
// command queue and back end. Depends on trrb_pkg and all trrb_* modules.
//
//   port group  direction  handshake            payload
//   in_         input      in_valid/in_ready    op, kind, thread_tag, location, target, stamp
//   out_        output     out_valid/out_ready  stored .. total_lost, one beat per input
//   APB         input      psel/penable/pwrite  paddr, pwdata, prdata (64 bit, 8-byte stride)
//
// A record beat is handled in state BK_IDLE alone; a drain that finds an entry
// also passes BK_READ, set by the registered read port of the ring memory. A beat
// passes a queue slot and the result register, a drain also the read data register.
// Reset is synchronous and clears pointers and counters; ring slots are not cleared.
// A stalled output holds the back end; the two-deep queue then fills and
// drops in_ready.
module trace_record_ring_buffer (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        in_op,
  input  logic [2:0]                  in_kind,
  input  logic [31:0]                 in_thread_tag,
  input  logic [63:0]                 in_location,
  input  logic [63:0]                 in_target,
  input  logic [63:0]                 in_stamp,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic                        out_stored,
  output logic                        out_dropped,
  output logic                        out_in_window,
  output logic                        out_out_valid,
  output logic [2:0]                  out_out_kind,
  output logic [31:0]                 out_out_thread,
  output logic [63:0]                 out_out_location,
  output logic [63:0]                 out_out_target,
  output logic [63:0]                 out_out_stamp,
  output logic                        out_now_empty,
  output logic [63:0]                 out_total_seen,
  output logic [63:0]                 out_total_lost,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [trrb_pkg::CFG_AW-1:0] paddr,
  input  logic [trrb_pkg::CFG_DW-1:0] pwdata,
  output logic [trrb_pkg::CFG_DW-1:0] prdata,
  output logic                        pready
);
  import trrb_pkg::*;

  cfg_t        cfg_r, cfg_nxt;
  logic        cfg_wr;
  logic [1:0]  reg_idx;
  logic        q_full, push, pop;
  cmd_t        push_cmd;
  q_head_t     q_head;
  result_t     result;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:3];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_comb begin
    cfg_nxt = cfg_r;
    prdata  = '0;
    case (reg_idx)
      REG_FILTER_EN: begin
        prdata = {{(CFG_DW-1){1'b0}}, cfg_r.filter_en};
        if (cfg_wr) cfg_nxt.filter_en = pwdata[0];
      end
      REG_WIN_BASE: begin
        prdata = cfg_r.win_base;
        if (cfg_wr) cfg_nxt.win_base = pwdata;
      end
      REG_WIN_END: begin
        prdata = cfg_r.win_end;
        if (cfg_wr) cfg_nxt.win_end = pwdata;
      end
      REG_STAMP_EN: begin
        prdata = {{(CFG_DW-1){1'b0}}, cfg_r.stamp_en};
        if (cfg_wr) cfg_nxt.stamp_en = pwdata[0];
      end
      default: begin
        prdata = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  trrb_front u_front (
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_op         (in_op),
    .in_kind       (in_kind),
    .in_thread_tag (in_thread_tag),
    .in_location   (in_location),
    .in_target     (in_target),
    .in_stamp      (in_stamp),
    .cfg           (cfg_r),
    .q_full        (q_full),
    .push          (push),
    .push_cmd      (push_cmd)
  );

  trrb_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .full     (q_full),
    .q_head   (q_head),
    .pop      (pop)
  );

  trrb_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_head    (q_head),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .result    (result)
  );

  assign out_stored       = result.stored;
  assign out_dropped      = result.dropped;
  assign out_in_window    = result.in_window;
  assign out_out_valid    = result.hit;
  assign out_out_kind     = result.entry.kind;
  assign out_out_thread   = result.entry.thread;
  assign out_out_location = result.entry.location;
  assign out_out_target   = result.entry.target;
  assign out_out_stamp    = result.entry.stamp;
  assign out_now_empty    = result.now_empty;
  assign out_total_seen   = result.total_seen;
  assign out_total_lost   = result.total_lost;

  // a drained entry never comes with a record outcome
  a_hit_not_record: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_out_valid |-> !out_stored && !out_dropped)
    else $error("drained entry flagged as stored or dropped");

  // a beat without an entry carries zero kind, thread, location and stamp fields
  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_out_valid |->
      out_out_kind == 3'd0 && out_out_thread == 32'd0 &&
      out_out_location == 64'd0 && out_out_stamp == 64'd0)
    else $error("entry fields nonzero without an entry");

  // a stored record leaves at least one entry in the ring
  a_hit_empty_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stored |-> !out_now_empty)
    else $error("ring reported empty right after a store");

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output beat right after reset");

endmodule
